// ===== rtl/hcm_pkg.sv =====
// ----------------------------------------------------------------------------
// hcm_pkg - shared types and constants for the height to colormap block
//
// Register and mode codes, channel source selects, the job word that travels
// from the classifying front to the divider back, and the result word.
// ----------------------------------------------------------------------------
`default_nettype none

package hcm_pkg;

  // largest supported color count
  localparam int MAX_COLORS = 65536;

  // quotient bits of the index divider and of the component dividers
  localparam int IDX_BITS  = 16;
  localparam int COMP_BITS = 16;

  // n / 3 as (n * DIV3_MUL) >> DIV3_SHIFT, exact for n below 2^17
  localparam logic [16:0] DIV3_MUL   = 17'd43691;
  localparam int          DIV3_SHIFT = 17;

  // 1.0 in Q0.16
  localparam logic [15:0] FULL_SCALE = 16'hFFFF;

  // default queue depths
  localparam int MID_Q_DEPTH = 4;
  localparam int RES_Q_DEPTH = 4;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_HEIGHT_MIN  = 2'd0,
    REG_HEIGHT_SPAN = 2'd1,
    REG_COLOR_COUNT = 2'd2,
    REG_MAP_MODE    = 2'd3
  } reg_idx_t;

  // color map selection
  typedef enum logic [1:0] {
    MODE_JET   = 2'd0,
    MODE_HUE   = 2'd1,
    MODE_GRAY  = 2'd2,
    MODE_WHITE = 2'd3
  } mode_t;

  // where one output channel takes its value from
  typedef enum logic [1:0] {
    SRC_ZERO = 2'd0,
    SRC_FULL = 2'd1,
    SRC_T0   = 2'd2,
    SRC_T1   = 2'd3
  } src_t;

  // classified item: index, channel selects and two component ratios
  typedef struct packed {
    logic [15:0] color_index;
    src_t        src_r;
    src_t        src_g;
    src_t        src_b;
    logic [16:0] num0;
    logic [16:0] den0;
    logic [16:0] num1;
    logic [16:0] den1;
  } job_t;

  // finished result
  typedef struct packed {
    logic [15:0] color_index;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/hcm_fifo.sv =====
// ----------------------------------------------------------------------------
// hcm_fifo - small first-in first-out queue
//
// Register based queue with a count; the head entry is shown directly on
// rdata while empty is low.
// ----------------------------------------------------------------------------
`default_nettype none

module hcm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic                  empty,
  output logic      [WIDTH-1:0] rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // store the incoming beat
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hcm_front.sv =====
// ----------------------------------------------------------------------------
// hcm_front - index pipeline and classifier
//
// Subtracts the minimum, scales by the color count, divides by the span one
// quotient bit per stage, clamps the index and turns it into a job: the two
// component ratios the back must work out and where each channel comes from.
// ----------------------------------------------------------------------------
`default_nettype none

module hcm_front import hcm_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic signed [31:0] in_height,
  input  wire logic signed [31:0] height_min,
  input  wire logic        [30:0] height_span,
  input  wire logic        [16:0] color_count,
  input  wire logic        [1:0]  map_mode,
  output logic                    job_push,
  input  wire logic               job_full,
  output job_t                    job
);

  localparam int NST = IDX_BITS;

  // derived configuration
  logic [16:0] n_raw;
  logic [16:0] n_eff;
  logic [30:0] span_eff;
  logic [33:0] n1_prod;
  logic [15:0] n1;
  logic [16:0] n2;
  logic [16:0] d_hi;

  // pipeline
  logic               adv;
  logic               s1_v;
  logic signed [32:0] s1_diff;
  logic [46:0]        prod_w;
  logic               dv_v   [0:NST];
  logic [46:0]        dv_rem [0:NST];
  logic [15:0]        dv_q   [0:NST];
  logic               dv_pos [0:NST];
  logic               dv_sat [0:NST];
  logic [46:0]        rem_next [1:NST];
  logic [15:0]        q_next   [1:NST];
  logic               s3_v;
  logic [15:0]        s3_c;
  logic               s4_v;
  logic [15:0]        s4_c;
  logic [16:0]        s4_c1;
  logic [19:0]        s4_six;
  logic               s4_lo;
  logic               s4_mid;
  logic               s5_v;
  job_t               s5_job;

  // classifier
  logic [16:0] hnum;
  logic [19:0] r1;
  logic [19:0] r2;
  logic [19:0] r3;
  logic [2:0]  sector;
  logic [16:0] hrem;
  logic [16:0] k_mid;
  job_t        job_next;

  // clamp count and span, precompute the jet thirds
  always_comb begin
    if (color_count == '0) begin
      n_raw = 17'd1;
    end else if (color_count > 17'(MAX_COLORS)) begin
      n_raw = 17'(MAX_COLORS);
    end else begin
      n_raw = color_count;
    end
    n1_prod = 34'(n_eff) * 34'(DIV3_MUL);
  end

  always_ff @(posedge clk) begin
    n_eff    <= n_raw;
    span_eff <= (height_span == '0) ? 31'd1 : height_span;
    n1       <= n1_prod[DIV3_SHIFT +: 16];
    n2       <= {n1, 1'b0};
    d_hi     <= n_eff - {n1, 1'b0};
  end

  // one global advance: hold the pipeline while a finished job waits on a full job queue
  assign adv      = !s5_v || !job_full;
  assign in_full  = !adv;
  assign job_push = s5_v && !job_full;
  assign job      = s5_job;

  // below the top diff fits 31 bits, so diff*n stays under 2^47
  assign prod_w = 47'(s1_diff[30:0]) * 47'(n_eff);

  // restoring division of diff*n by span, one quotient bit per stage
  always_comb begin
    logic [46:0] trial;
    for (int k = 1; k <= NST; k++) begin
      trial       = 47'(span_eff) << (NST - k);
      if (dv_rem[k-1] >= trial) begin
        rem_next[k] = dv_rem[k-1] - trial;
        q_next[k]   = {dv_q[k-1][14:0], 1'b1};
      end else begin
        rem_next[k] = dv_rem[k-1];
        q_next[k]   = {dv_q[k-1][14:0], 1'b0};
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      for (int k = 0; k <= NST; k++) begin
        dv_v[k] <= 1'b0;
      end
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
    end else if (adv) begin
      s1_v    <= in_push;
      dv_v[0] <= s1_v;
      for (int k = 1; k <= NST; k++) begin
        dv_v[k] <= dv_v[k-1];
      end
      s3_v <= dv_v[NST];
      s4_v <= s3_v;
      s5_v <= s4_v;
    end
  end

  // index datapath
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_diff <= {in_height[31], in_height} - {height_min[31], height_min};

      dv_rem[0] <= prod_w;
      dv_q[0]   <= '0;
      dv_pos[0] <= !s1_diff[32] && (s1_diff != '0);
      dv_sat[0] <= s1_diff[31:0] >= {1'b0, span_eff};
      for (int k = 1; k <= NST; k++) begin
        dv_rem[k] <= rem_next[k];
        dv_q[k]   <= q_next[k];
        dv_pos[k] <= dv_pos[k-1];
        dv_sat[k] <= dv_sat[k-1];
      end

      // clamp: below the minimum gives 0, at or past the top gives n-1
      if (!dv_pos[NST]) begin
        s3_c <= '0;
      end else if (dv_sat[NST]) begin
        s3_c <= 16'(n_eff - 17'd1);
      end else begin
        s3_c <= dv_q[NST];
      end

      s4_c   <= s3_c;
      s4_c1  <= {1'b0, s3_c} + 17'd1;
      s4_six <= {1'b0, hnum, 2'b00} + {2'b00, hnum, 1'b0};
      s4_lo  <= s3_c < n1;
      s4_mid <= {1'b0, s3_c} < n2;

      s5_job <= job_next;
    end
  end

  // hue numerator, with hue 1.0 wrapping to 0
  assign hnum = (({1'b0, s3_c} + 17'd1) == n_eff) ? '0 : {1'b0, s3_c} + 17'd1;

  // hue sector and remainder of 6*num / n
  always_comb begin
    sector[2] = s4_six >= {1'b0, n_eff, 2'b00};
    r1        = sector[2] ? s4_six - {1'b0, n_eff, 2'b00} : s4_six;
    sector[1] = r1 >= {2'b00, n_eff, 1'b0};
    r2        = sector[1] ? r1 - {2'b00, n_eff, 1'b0} : r1;
    sector[0] = r2 >= {3'b000, n_eff};
    r3        = sector[0] ? r2 - {3'b000, n_eff} : r2;
    hrem      = r3[16:0];
    k_mid     = {1'b0, s4_c} - {1'b0, n1};
  end

  // classify: pick the ratios and the channel sources for the selected map
  always_comb begin
    job_next             = '0;
    job_next.color_index = s4_c;
    job_next.src_r       = SRC_FULL;
    job_next.src_g       = SRC_FULL;
    job_next.src_b       = SRC_FULL;
    unique case (mode_t'(map_mode))
      MODE_JET: begin
        if (s4_lo) begin
          job_next.num0  = {1'b0, s4_c};
          job_next.den0  = {1'b0, n1};
          job_next.src_r = SRC_ZERO;
          job_next.src_g = SRC_T0;
          job_next.src_b = SRC_FULL;
        end else if (s4_mid) begin
          job_next.num0  = k_mid;
          job_next.den0  = {1'b0, n1};
          job_next.num1  = {1'b0, n1} - k_mid;
          job_next.den1  = {1'b0, n1};
          job_next.src_r = SRC_T0;
          job_next.src_g = SRC_FULL;
          job_next.src_b = SRC_T1;
        end else begin
          job_next.num0  = n_eff - s4_c1;
          job_next.den0  = d_hi;
          job_next.src_r = SRC_FULL;
          job_next.src_g = SRC_T0;
          job_next.src_b = SRC_ZERO;
        end
      end
      MODE_HUE: begin
        job_next.num0 = hrem;
        job_next.den0 = n_eff;
        job_next.num1 = n_eff - hrem;
        job_next.den1 = n_eff;
        case (sector)
          3'd0: begin
            job_next.src_r = SRC_FULL;
            job_next.src_g = SRC_T0;
            job_next.src_b = SRC_ZERO;
          end
          3'd1: begin
            job_next.src_r = SRC_T1;
            job_next.src_g = SRC_FULL;
            job_next.src_b = SRC_ZERO;
          end
          3'd2: begin
            job_next.src_r = SRC_ZERO;
            job_next.src_g = SRC_FULL;
            job_next.src_b = SRC_T0;
          end
          3'd3: begin
            job_next.src_r = SRC_ZERO;
            job_next.src_g = SRC_T1;
            job_next.src_b = SRC_FULL;
          end
          3'd4: begin
            job_next.src_r = SRC_T0;
            job_next.src_g = SRC_ZERO;
            job_next.src_b = SRC_FULL;
          end
          default: begin
            job_next.src_r = SRC_FULL;
            job_next.src_g = SRC_ZERO;
            job_next.src_b = SRC_T1;
          end
        endcase
      end
      MODE_GRAY: begin
        job_next.num0  = s4_c1;
        job_next.den0  = n_eff;
        job_next.src_r = SRC_T0;
        job_next.src_g = SRC_T0;
        job_next.src_b = SRC_T0;
      end
      default: begin
        job_next.src_r = SRC_FULL;
        job_next.src_g = SRC_FULL;
        job_next.src_b = SRC_FULL;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/hcm_back.sv =====
// ----------------------------------------------------------------------------
// hcm_back - component dividers and color assembly
//
// Two pipelined dividers work out round(num/den * 65535) for each job, one
// quotient bit per stage; the last stage routes them onto red, green, blue.
// ----------------------------------------------------------------------------
`default_nettype none

module hcm_back import hcm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic job_empty,
  output logic      job_pop,
  input  wire job_t job,
  output logic      res_push,
  input  wire logic res_full,
  output res_t      res
);

  localparam int NST = COMP_BITS;

  logic        adv;
  logic        b_v    [0:NST];
  logic [15:0] b_idx  [0:NST];
  src_t        b_sr   [0:NST];
  src_t        b_sg   [0:NST];
  src_t        b_sb   [0:NST];
  logic [33:0] b_rem  [0:1][0:NST];
  logic [17:0] b_dvs  [0:1][0:NST];
  logic        b_z    [0:1][0:NST];
  logic [15:0] b_q    [0:1][0:NST];
  logic [33:0] rem_next [0:1][1:NST];
  logic [15:0] q_next   [0:1][1:NST];
  logic [16:0] num_in [0:1];
  logic [16:0] den_in [0:1];
  logic [16:0] num_c  [0:1];
  logic [33:0] dvd_in [0:1];
  logic [15:0] t0;
  logic [15:0] t1;

  function automatic logic [15:0] pick(input src_t s, input logic [15:0] a,
                                       input logic [15:0] b);
    logic [15:0] v;
    case (s)
      SRC_ZERO: v = '0;
      SRC_FULL: v = FULL_SCALE;
      SRC_T0:   v = a;
      SRC_T1:   v = b;
      default:  v = '0;
    endcase
    return v;
  endfunction

  // hold the whole pipe while a finished result waits on a full result queue
  assign adv      = !(b_v[NST] && res_full);
  assign job_pop  = adv && !job_empty;
  assign res_push = b_v[NST] && !res_full;

  // set up dividend num*2*65535 + den and divisor 2*den, num clamped to den
  always_comb begin
    num_in[0] = job.num0;
    den_in[0] = job.den0;
    num_in[1] = job.num1;
    den_in[1] = job.den1;
    for (int u = 0; u < 2; u++) begin
      num_c[u]  = (num_in[u] > den_in[u]) ? den_in[u] : num_in[u];
      dvd_in[u] = {num_c[u], 17'b0} - {16'b0, num_c[u], 1'b0} + {17'b0, den_in[u]};
    end
  end

  // one quotient bit per stage for both units
  always_comb begin
    logic [33:0] trial;
    for (int u = 0; u < 2; u++) begin
      for (int k = 1; k <= NST; k++) begin
        trial = 34'(b_dvs[u][k-1]) << (NST - k);
        if (b_rem[u][k-1] >= trial) begin
          rem_next[u][k] = b_rem[u][k-1] - trial;
          q_next[u][k]   = {b_q[u][k-1][14:0], 1'b1};
        end else begin
          rem_next[u][k] = b_rem[u][k-1];
          q_next[u][k]   = {b_q[u][k-1][14:0], 1'b0};
        end
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= NST; k++) begin
        b_v[k] <= 1'b0;
      end
    end else if (adv) begin
      b_v[0] <= job_pop;
      for (int k = 1; k <= NST; k++) begin
        b_v[k] <= b_v[k-1];
      end
    end
  end

  // divider datapath and sideband
  always_ff @(posedge clk) begin
    if (adv) begin
      b_idx[0] <= job.color_index;
      b_sr[0]  <= job.src_r;
      b_sg[0]  <= job.src_g;
      b_sb[0]  <= job.src_b;
      for (int u = 0; u < 2; u++) begin
        b_rem[u][0] <= dvd_in[u];
        b_dvs[u][0] <= {den_in[u], 1'b0};
        b_z[u][0]   <= (den_in[u] == '0);
        b_q[u][0]   <= '0;
      end
      for (int k = 1; k <= NST; k++) begin
        b_idx[k] <= b_idx[k-1];
        b_sr[k]  <= b_sr[k-1];
        b_sg[k]  <= b_sg[k-1];
        b_sb[k]  <= b_sb[k-1];
        for (int u = 0; u < 2; u++) begin
          b_rem[u][k] <= rem_next[u][k];
          b_dvs[u][k] <= b_dvs[u][k-1];
          b_z[u][k]   <= b_z[u][k-1];
          b_q[u][k]   <= q_next[u][k];
        end
      end
    end
  end

  // drop the quotient of an empty ratio, route onto the channels
  assign t0 = b_z[0][NST] ? '0 : b_q[0][NST];
  assign t1 = b_z[1][NST] ? '0 : b_q[1][NST];

  always_comb begin
    res.color_index = b_idx[NST];
    res.red         = pick(b_sr[NST], t0, t1);
    res.green       = pick(b_sg[NST], t0, t1);
    res.blue        = pick(b_sb[NST], t0, t1);
  end

endmodule

`default_nettype wire

// ===== rtl/height_to_colormap.sv =====
// ----------------------------------------------------------------------------
// height_to_colormap - point height to RGB pseudo-color
//
//   channel   ports                                  handshake
//   --------  -------------------------------------  -----------------------
//   input     height                                 push / full
//   result    color_index, red, green, blue          empty / pop
//   config    cfg_index, cfg_data                    cfg_we, no wait
//
// One item per cycle sustained while neither queue is full. A result passes
// through 21 front stages (16 of them the index divider), the job queue, then
// 17 back stages (16 per component divider) and the result queue. Reset puts
// the registers to their defaults and empties both queues.
// A full job queue stops the front and raises full; a full result queue
// stops the back, which then fills the job queue.
// ----------------------------------------------------------------------------
`default_nettype none

module height_to_colormap import hcm_pkg::*; #(
  parameter int MID_DEPTH = MID_Q_DEPTH,
  parameter int RES_DEPTH = RES_Q_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic signed [31:0] height,
  output logic                    empty,
  input  wire logic               pop,
  output logic             [15:0] color_index,
  output logic             [15:0] red,
  output logic             [15:0] green,
  output logic             [15:0] blue,
  input  wire logic               cfg_we,
  input  wire logic        [1:0]  cfg_index,
  input  wire logic        [31:0] cfg_data
);

  logic signed [31:0] height_min;
  logic        [30:0] height_span;
  logic        [16:0] color_count;
  logic        [1:0]  map_mode;

  logic job_push;
  logic job_full;
  logic job_empty;
  logic job_pop;
  job_t job_front;
  job_t job_back;
  logic res_push;
  logic res_full;
  res_t res_back;
  res_t res_head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      height_min  <= '0;
      height_span <= 31'd65536;
      color_count <= 17'd256;
      map_mode    <= MODE_JET;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_HEIGHT_MIN:  height_min  <= cfg_data;
        REG_HEIGHT_SPAN: height_span <= cfg_data[30:0];
        REG_COLOR_COUNT: color_count <= cfg_data[16:0];
        REG_MAP_MODE:    map_mode    <= cfg_data[1:0];
        default:         height_min  <= height_min;
      endcase
    end
  end

  hcm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_push     (push),
    .in_full     (full),
    .in_height   (height),
    .height_min  (height_min),
    .height_span (height_span),
    .color_count (color_count),
    .map_mode    (map_mode),
    .job_push    (job_push),
    .job_full    (job_full),
    .job         (job_front)
  );

  hcm_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (MID_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .full  (job_full),
    .wdata (job_front),
    .pop   (job_pop),
    .empty (job_empty),
    .rdata (job_back)
  );

  hcm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .job       (job_back),
    .res_push  (res_push),
    .res_full  (res_full),
    .res       (res_back)
  );

  hcm_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .full  (res_full),
    .wdata (res_back),
    .pop   (pop),
    .empty (empty),
    .rdata (res_head)
  );

  assign color_index = res_head.color_index;
  assign red         = res_head.red;
  assign green       = res_head.green;
  assign blue        = res_head.blue;

endmodule

`default_nettype wire

// ===== rtl/hcm_checker.sv =====
// ----------------------------------------------------------------------------
// hcm_checker - port level checks for height_to_colormap
//
// Watches the queue handshakes on both sides and the result payload; bound
// to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

module hcm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        push,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [15:0] color_index,
  input wire logic [15:0] red,
  input wire logic [15:0] green,
  input wire logic [15:0] blue
);

  logic [7:0] outstanding;
  logic       in_beat;
  logic       out_beat;

  assign in_beat  = push && !full;
  assign out_beat = pop && !empty;

  // count beats taken in but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + 8'(in_beat) - 8'(out_beat);
    end
  end

  // reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result shown right after reset");

  // reset leaves the input open
  a_reset_open: assert property (@(posedge clk) rst |=> !full)
    else $error("input blocked right after reset");

  // every result has an item behind it
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (outstanding != '0))
    else $error("result without a pending item");

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(color_index) && $stable(red) &&
                          $stable(green) && $stable(blue)))
    else $error("waiting result changed");

endmodule

bind height_to_colormap hcm_checker u_hcm_checker (
  .clk         (clk),
  .rst         (rst),
  .push        (push),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .color_index (color_index),
  .red         (red),
  .green       (green),
  .blue        (blue)
);

`default_nettype wire
